// ----- rtl/core/ebd_pkg.sv -----
// ----------------------------------------------------------------------------
// ebd_pkg: shared types and constants for the encoder button event detector
// Word layouts of both channels, button event codes, register indexes and
// register reset values.
// ----------------------------------------------------------------------------
package ebd_pkg;

    // Default width of the press and click tick counters
    localparam int TICK_WIDTH_DEF = 16;

    // Configuration port widths
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_PRESENT      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_THRESHOLD      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 3'd3;

    // Register reset values
    localparam logic        BUTTON_PRESENT_RST      = 1'b1;
    localparam logic [7:0]  STEP_THRESHOLD_RST      = 8'd3;
    localparam logic [15:0] HOLD_TICKS_RST          = 16'd50;
    localparam logic [15:0] DOUBLE_CLICK_WINDOW_RST = 16'd25;

    // Input word modes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Button event codes
    typedef enum logic [2:0] {
        EV_OPEN     = 3'd0,
        EV_PUSHED   = 3'd1,
        EV_DOUBLE   = 3'd2,
        EV_HOLD     = 3'd3,
        EV_RELEASED = 3'd4
    } t_button_event;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] position;
        logic               pin_level;
    } t_in_word;

    typedef struct packed {
        logic       moved;
        logic       step_up;
        logic       step_down;
        logic [2:0] button_state;
    } t_out_word;

endpackage

// ----- rtl/core/ebd_button.sv -----
// ----------------------------------------------------------------------------
// ebd_button: push switch press classifier
// Tracks press length and the click countdown on every sample tick, and
// holds the pending button event until a read clears it; a read keeps hold.
// ----------------------------------------------------------------------------
module ebd_button
    import ebd_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tick,
    input  logic          i_read,
    input  logic          i_pressed,
    input  logic [15:0]   i_hold_ticks,
    input  logic [15:0]   i_window,
    output t_button_event o_event
);

    // Compare width: wide enough for both the counters and the registers
    localparam int CW = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

    logic [TICK_WIDTH-1:0] r_press_ticks, n_press_ticks;
    logic [TICK_WIDTH-1:0] r_click_countdown, n_click_countdown;
    t_button_event         r_event, n_event;
    logic                  r_prev_pressed, n_prev_pressed;

    logic [CW-1:0]         window_ext;
    logic [TICK_WIDTH-1:0] window_sat;

    // Saturate the countdown load to the counter range
    always_comb begin
        window_ext = CW'(i_window);
        if (window_ext > CW'(TICK_MAX)) begin
            window_sat = TICK_MAX;
        end else begin
            window_sat = TICK_WIDTH'(window_ext);
        end
    end

    // Next state for a tick or a read
    always_comb begin
        n_press_ticks     = r_press_ticks;
        n_click_countdown = r_click_countdown;
        n_event           = r_event;
        n_prev_pressed    = r_prev_pressed;
        if (i_read) begin
            if (r_event != EV_HOLD) begin
                n_event = EV_OPEN;
            end
        end else if (i_tick) begin
            if (i_pressed == r_prev_pressed) begin
                if (i_pressed) begin
                    // count stable pressed ticks, hold once beyond the limit
                    if (r_press_ticks != TICK_MAX) begin
                        n_press_ticks = r_press_ticks + 1'b1;
                    end
                    if (CW'(n_press_ticks) > CW'(i_hold_ticks)) begin
                        n_event = EV_HOLD;
                    end
                end else begin
                    // stable release ends the press
                    if (r_press_ticks != '0) begin
                        if (r_event == EV_HOLD) begin
                            n_event           = EV_RELEASED;
                            n_click_countdown = '0;
                        end else if (r_click_countdown > TICK_WIDTH'(1)) begin
                            if (CW'(r_click_countdown) < window_ext) begin
                                n_event           = EV_DOUBLE;
                                n_click_countdown = '0;
                            end
                        end else begin
                            n_click_countdown = window_sat;
                        end
                    end
                    n_press_ticks = '0;
                end
            end
            // run the countdown, report pushed when it expires
            if (n_click_countdown != '0) begin
                n_click_countdown = n_click_countdown - 1'b1;
                if (n_click_countdown == '0) begin
                    n_event = EV_PUSHED;
                end
            end
            n_prev_pressed = i_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_ticks     <= '0;
            r_click_countdown <= '0;
            r_event           <= EV_OPEN;
            r_prev_pressed    <= 1'b0;
        end else begin
            r_press_ticks     <= n_press_ticks;
            r_click_countdown <= n_click_countdown;
            r_event           <= n_event;
            r_prev_pressed    <= n_prev_pressed;
        end
    end

    assign o_event = r_event;

endmodule

// ----- rtl/core/encoder_button_event_detector.sv -----
// ----------------------------------------------------------------------------
// encoder_button_event_detector: rotary encoder step and push button events
// Reports encoder steps per sample tick and classifies button presses.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in_word) takes one word per
//   cycle. A sample tick word (mode 0) carries the encoder count and the
//   raw switch level; a read word (mode 1) fetches the pending button
//   event and clears it unless it is hold on.
//   Output channel (o_out_valid/i_out_ready/o_out_word) gives exactly one
//   word per input word, in order. The result is registered: it sits
//   in the output register in the cycle after acceptance.
//   Throughput is one word per cycle; all work is one pass of shallow
//   logic between the accepted word and the output register.
//   When the receiver stalls, the output register holds its word and the
//   input side stops taking words until it is taken; no word is dropped.
//   Configuration writes (i_cfg_*) are taken in any cycle; an index
//   beyond the register list is ignored.
//   Reset clears the step and button state, empties the output register
//   and restores register defaults (switch fitted, threshold 3, hold 50,
//   double click window 25).
// ----------------------------------------------------------------------------
module encoder_button_event_detector
    import ebd_pkg::*;
#(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_word               i_in_word,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_word              o_out_word
);

    logic        r_button_present;
    logic [7:0]  r_step_threshold;
    logic [15:0] r_hold_ticks;
    logic [15:0] r_double_click_window;

    logic signed [31:0] r_last_position;
    logic               r_out_valid;
    t_out_word          r_out_word, n_out_word;

    logic               accept;
    logic               tick_en;
    logic               read_en;
    logic signed [32:0] diff;
    logic signed [32:0] thr;
    logic               up;
    logic               down;
    t_button_event      button_event;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_present      <= BUTTON_PRESENT_RST;
            r_step_threshold      <= STEP_THRESHOLD_RST;
            r_hold_ticks          <= HOLD_TICKS_RST;
            r_double_click_window <= DOUBLE_CLICK_WINDOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BUTTON_PRESENT:      r_button_present      <= i_cfg_data[0];
                REG_STEP_THRESHOLD:      r_step_threshold      <= i_cfg_data[7:0];
                REG_HOLD_TICKS:          r_hold_ticks          <= i_cfg_data;
                REG_DOUBLE_CLICK_WINDOW: r_double_click_window <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take a word whenever the output register is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tick_en    = accept && (i_in_word.mode == MODE_TICK);
    assign read_en    = accept && (i_in_word.mode == MODE_READ);

    // Exact signed step compare against the count of the last reported step
    always_comb begin
        diff = 33'(i_in_word.position) - 33'(r_last_position);
        thr  = $signed({25'd0, r_step_threshold});
        up   = diff > thr;
        down = diff < -thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_position <= '0;
        end else if (tick_en && (up || down)) begin
            r_last_position <= i_in_word.position;
        end
    end

    ebd_button #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_button (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_en && r_button_present),
        .i_read       (read_en),
        .i_pressed    (!i_in_word.pin_level),
        .i_hold_ticks (r_hold_ticks),
        .i_window     (r_double_click_window),
        .o_event      (button_event)
    );

    // Build the result word
    always_comb begin
        n_out_word = '0;
        if (i_in_word.mode == MODE_READ) begin
            n_out_word.button_state = button_event;
        end else begin
            n_out_word.moved     = up || down;
            n_out_word.step_up   = up;
            n_out_word.step_down = down;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- rtl/core/ebd_checker.sv -----
// ----------------------------------------------------------------------------
// ebd_checker: port level checks for the encoder button event detector
// Watches the top level ports and flags inconsistent result words and stalls.
// ----------------------------------------------------------------------------
module ebd_checker
    import ebd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // A step goes one way only
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.step_up && o_out_word.step_down))
        else $error("ebd: step up and step down together");

    // Moved flags exactly a reported step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.moved == (o_out_word.step_up || o_out_word.step_down)))
        else $error("ebd: moved does not match step flags");

    // A word with a button state carries no movement
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.button_state != EV_OPEN)) |-> !o_out_word.moved)
        else $error("ebd: button state and movement in one word");

    // A stalled result blocks the input side
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("ebd: input taken while output stalled");

    // A stalled result word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("ebd: stalled output word changed");

endmodule

bind encoder_button_event_detector ebd_checker u_ebd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
